// ===== design/shs_pkg.sv =====
// Shared types, command codes and the half-step coil table for the stepper homing unit.
package shs_pkg;

	localparam int POS_W = 32;
	localparam int FAR_W = 30;
	localparam int IVL_W = 16;
	localparam int PHASE_W = 3;
	localparam int TIME_W = 32;

	localparam logic [1:0] CMD_SET_TARGET = 2'd0;
	localparam logic [1:0] CMD_STEP_TICK = 2'd1;
	localparam logic [1:0] CMD_HOMING_POLL = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [1:0] REG_EDGE_LEVEL = 2'd0;
	localparam logic [1:0] REG_MAIN_TURN_POSITIVE = 2'd1;
	localparam logic [1:0] REG_SLOW_STEP_INTERVAL = 2'd2;
	localparam logic [1:0] REG_FAR_DISTANCE = 2'd3;

	localparam logic [PHASE_W-1:0] PH_PRE_TURN = 3'd0;
	localparam logic [PHASE_W-1:0] PH_MAIN_TURN = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ZEROING = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CREEP = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic signed [31:0] target_pos;
		logic signed [31:0] target_offset;
		logic sensor_level;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic stepped;
		logic signed [31:0] actual_position;
		logic homing_done;
	} out_word_t;

	typedef struct packed {
		logic edge_level;
		logic main_turn_positive;
		logic [IVL_W-1:0] slow_step_interval;
		logic [FAR_W-1:0] far_distance;
	} cfg_t;

	// Result of one step tick.
	typedef struct packed {
		logic moved;
		logic [POS_W-1:0] position;
		logic [3:0] coils;
	} step_res_t;

	// Updates requested by one homing poll.
	typedef struct packed {
		logic load_target;
		logic [POS_W-1:0] target;
		logic zero_pos;
		logic load_stamp;
		logic [PHASE_W-1:0] phase;
		logic done;
	} home_upd_t;

	function automatic logic [3:0] half_step_row(input logic [2:0] idx);
		logic [3:0] row;
		unique case (idx)
			3'd0: row = 4'h1;
			3'd1: row = 4'h5;
			3'd2: row = 4'h4;
			3'd3: row = 4'h6;
			3'd4: row = 4'h2;
			3'd5: row = 4'hA;
			3'd6: row = 4'h8;
			default: row = 4'h9;
		endcase
		return row;
	endfunction

endpackage

// ===== design/shs_step.sv =====
// Step tick logic: one step toward target plus offset and the coil pattern lookup.
module shs_step (
	input  logic [shs_pkg::POS_W-1:0] target,
	input  logic [shs_pkg::POS_W-1:0] shift,
	input  logic [shs_pkg::POS_W-1:0] motor,
	output shs_pkg::step_res_t        res
);

	logic [shs_pkg::POS_W-1:0] goal;
	logic [shs_pkg::POS_W-1:0] next_pos;
	logic up;
	logic down;

	assign goal = target + shift;
	assign up = $signed(goal) > $signed(motor);
	assign down = $signed(goal) < $signed(motor);

	always_comb begin
		if (up) begin
			next_pos = motor + shs_pkg::POS_W'(1);
		end else begin
			next_pos = motor - shs_pkg::POS_W'(1);
		end
	end

	assign res.moved = up | down;
	assign res.position = next_pos;
	assign res.coils = shs_pkg::half_step_row(next_pos[2:0]);

endmodule

// ===== design/shs_home.sv =====
// Homing poll logic: the five-phase sequence with its fall-through resolved in one pass.
module shs_home (
	input  shs_pkg::cfg_t                 cfg,
	input  logic [shs_pkg::PHASE_W-1:0]   phase,
	input  logic [shs_pkg::POS_W-1:0]     target,
	input  logic [shs_pkg::TIME_W-1:0]    stamp,
	input  logic                          level,
	input  logic [shs_pkg::TIME_W-1:0]    now,
	output shs_pkg::home_upd_t            upd
);

	logic at_edge;
	logic [shs_pkg::POS_W-1:0] far_plus;
	logic [shs_pkg::POS_W-1:0] far_minus;
	logic [shs_pkg::POS_W-1:0] far_main;
	logic [shs_pkg::POS_W-1:0] far_back;
	logic [shs_pkg::TIME_W-1:0] elapsed;
	logic creep_due;

	assign at_edge = (level == cfg.edge_level);
	assign far_plus = shs_pkg::POS_W'(cfg.far_distance);
	assign far_minus = shs_pkg::POS_W'(0) - far_plus;
	assign far_main = cfg.main_turn_positive ? far_plus : far_minus;
	assign far_back = cfg.main_turn_positive ? far_minus : far_plus;
	assign elapsed = now - stamp;
	assign creep_due = elapsed > shs_pkg::TIME_W'(cfg.slow_step_interval);

	always_comb begin
		upd.load_target = 1'b0;
		upd.target = far_main;
		upd.zero_pos = 1'b0;
		upd.load_stamp = 1'b0;
		upd.phase = phase;
		upd.done = 1'b0;
		unique case (phase)
			shs_pkg::PH_PRE_TURN: begin
				// At the edge: back off first; otherwise go straight into the main turn.
				upd.load_target = 1'b1;
				if (at_edge) begin
					upd.target = far_back;
					upd.phase = shs_pkg::PH_MAIN_TURN;
				end else begin
					upd.phase = shs_pkg::PH_ZEROING;
				end
			end
			shs_pkg::PH_MAIN_TURN: begin
				if (!at_edge) begin
					upd.load_target = 1'b1;
					upd.phase = shs_pkg::PH_ZEROING;
				end
			end
			shs_pkg::PH_ZEROING: begin
				// Reaching the edge zeroes the positions; the creep check that follows
				// sees zero elapsed time and never moves in the same poll.
				if (at_edge) begin
					upd.zero_pos = 1'b1;
					upd.load_stamp = 1'b1;
					upd.phase = shs_pkg::PH_CREEP;
				end
			end
			shs_pkg::PH_CREEP: begin
				if (!at_edge) begin
					upd.zero_pos = 1'b1;
					upd.phase = shs_pkg::PH_DONE;
				end else if (creep_due) begin
					upd.load_target = 1'b1;
					upd.target = target + far_back;
					upd.load_stamp = 1'b1;
				end
			end
			shs_pkg::PH_DONE: begin
				upd.done = 1'b1;
			end
			default: begin
				upd.phase = shs_pkg::PH_PRE_TURN;
			end
		endcase
	end

endmodule

// ===== design/stepper_half_step_homing_unit.sv =====
// Top level of the half-step stepper sequencer with homing: registers, handshake and state.
// An accepted word waits in the input register and becomes a result word when it moves on
// into the result register, which it does only while that register is empty or draining.
// Throughput: one word per cycle while results are taken; the input and result registers
// are the only stages, and all state is updated when a word moves from one to the other.
// Reset (arst_n low, asynchronous) clears positions, phase, time stamp and coils,
// empties both stages, and restores the register defaults.
module stepper_half_step_homing_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [shs_pkg::FAR_W-1:0] wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  shs_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output shs_pkg::out_word_t   out_word
);

	// Configuration registers.
	shs_pkg::cfg_t cfg_q;

	// Input stage: the accepted word waits here until the result register can take it.
	logic valid_s1;
	shs_pkg::in_word_t item_s1;

	// Result register.
	logic out_valid_q;
	shs_pkg::out_word_t out_word_q;

	// Sequencer state.
	logic [shs_pkg::POS_W-1:0] target_q;
	logic [shs_pkg::POS_W-1:0] shift_q;
	logic [shs_pkg::POS_W-1:0] motor_q;
	logic [shs_pkg::PHASE_W-1:0] phase_q;
	logic [shs_pkg::TIME_W-1:0] stamp_q;
	logic [3:0] drive_q;

	logic advance;
	shs_pkg::step_res_t step_res;
	shs_pkg::home_upd_t home_upd;

	logic [shs_pkg::POS_W-1:0] target_d;
	logic [shs_pkg::POS_W-1:0] shift_d;
	logic [shs_pkg::POS_W-1:0] motor_d;
	logic [shs_pkg::PHASE_W-1:0] phase_d;
	logic [shs_pkg::TIME_W-1:0] stamp_d;
	logic [3:0] drive_d;
	logic stepped_d;
	logic done_d;

	// A word leaves the input stage whenever the result register is empty or being
	// drained, so the input stage can take a new word in the same cycle that its
	// current word moves on. A full input stage behind a waiting result holds the input.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	shs_step u_step (
		.target (target_q),
		.shift  (shift_q),
		.motor  (motor_q),
		.res    (step_res)
	);

	shs_home u_home (
		.cfg    (cfg_q),
		.phase  (phase_q),
		.target (target_q),
		.stamp  (stamp_q),
		.level  (item_s1.sensor_level),
		.now    (item_s1.now_ms),
		.upd    (home_upd)
	);

	// Next state for the word in the input stage.
	always_comb begin
		target_d = target_q;
		shift_d = shift_q;
		motor_d = motor_q;
		phase_d = phase_q;
		stamp_d = stamp_q;
		drive_d = drive_q;
		stepped_d = 1'b0;
		done_d = 1'b0;
		unique case (item_s1.command)
			shs_pkg::CMD_SET_TARGET: begin
				target_d = shs_pkg::POS_W'(item_s1.target_pos);
				shift_d = shs_pkg::POS_W'(item_s1.target_offset);
			end
			shs_pkg::CMD_STEP_TICK: begin
				// The coil pattern only changes when the motor actually moves.
				if (step_res.moved) begin
					motor_d = step_res.position;
					drive_d = step_res.coils;
					stepped_d = 1'b1;
				end
			end
			shs_pkg::CMD_HOMING_POLL: begin
				// Zeroing wins over a target load; both never come from the same poll.
				if (home_upd.load_target) begin
					target_d = home_upd.target;
				end
				if (home_upd.zero_pos) begin
					target_d = '0;
					shift_d = '0;
					motor_d = '0;
				end
				if (home_upd.load_stamp) begin
					stamp_d = item_s1.now_ms;
				end
				phase_d = home_upd.phase;
				done_d = home_upd.done;
			end
			shs_pkg::CMD_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_level <= 1'b1;
			cfg_q.main_turn_positive <= 1'b1;
			cfg_q.slow_step_interval <= shs_pkg::IVL_W'(20);
			cfg_q.far_distance <= shs_pkg::FAR_W'(100000);
		end else if (wr_en) begin
			unique case (wr_index)
				shs_pkg::REG_EDGE_LEVEL: cfg_q.edge_level <= wr_data[0];
				shs_pkg::REG_MAIN_TURN_POSITIVE: cfg_q.main_turn_positive <= wr_data[0];
				shs_pkg::REG_SLOW_STEP_INTERVAL: begin
					cfg_q.slow_step_interval <= wr_data[shs_pkg::IVL_W-1:0];
				end
				shs_pkg::REG_FAR_DISTANCE: cfg_q.far_distance <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_word;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.coil_pattern <= drive_d;
			out_word_q.stepped <= stepped_d;
			out_word_q.actual_position <= 32'(signed'(motor_d));
			out_word_q.homing_done <= done_d;
		end
	end

	// Sequencer state, updated once per word as it moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			shift_q <= '0;
			motor_q <= '0;
			phase_q <= shs_pkg::PH_PRE_TURN;
			stamp_q <= '0;
			drive_q <= '0;
		end else if (advance) begin
			target_q <= target_d;
			shift_q <= shift_d;
			motor_q <= motor_d;
			phase_q <= phase_d;
			stamp_q <= stamp_d;
			drive_q <= drive_d;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the half-step stepper sequencer with homing.
`timescale 1ns / 100ps

module tb_top;

	// One directed stimulus word, with a hand-written result where it is obvious.
	typedef struct {
		shs_pkg::in_word_t  word;
		bit                 known;
		shs_pkg::out_word_t typed;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [1:0] wr_index;
	logic [shs_pkg::FAR_W-1:0] wr_data;
	logic       in_valid;
	logic       in_ready;
	shs_pkg::in_word_t  in_word;
	logic       out_valid;
	logic       out_ready;
	shs_pkg::out_word_t out_word;

	stepper_half_step_homing_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// The clock has a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Our own copy of the register settings and of the block's state. The
	// settings start at the documented reset defaults.
	shs_pkg::cfg_t cfg;
	logic [31:0] tgt_pos;
	logic [31:0] tgt_shift;
	logic [31:0] motor_pos;
	logic [shs_pkg::PHASE_W-1:0] home_phase;
	logic [31:0] creep_mark;
	logic [3:0]  coil_bits;

	// Half-step coil drive, indexed by the low three bits of the position.
	logic [3:0] coil_rows [8] = '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};

	// Result words that are still owed by the block, oldest first.
	shs_pkg::out_word_t pending_out_words [$];

	int  err_count;
	int  words_checked;
	int  moves_seen;
	int  done_seen;
	int  settings_used;
	// While this is set, neither side idles.
	bit  steady;

	// Works out the result word that one input word causes and moves the
	// local state along, in the same way the block does.
	function automatic shs_pkg::out_word_t predict_out_word(input shs_pkg::in_word_t w);
		shs_pkg::out_word_t r;
		logic signed [31:0] goal;
		logic signed [31:0] here;
		logic [31:0] far_pos;
		logic [31:0] far_neg;
		logic [31:0] elapsed;
		logic at_edge;
		logic go;
		logic moved;
		logic dn;
		moved = 1'b0;
		dn = 1'b0;
		far_pos = {2'b00, cfg.far_distance};
		far_neg = 32'd0 - far_pos;
		at_edge = (w.sensor_level == cfg.edge_level);
		case (w.command)
			shs_pkg::CMD_SET_TARGET: begin
				tgt_pos = w.target_pos;
				tgt_shift = w.target_offset;
			end
			shs_pkg::CMD_STEP_TICK: begin
				// The goal is compared as a signed number after the wrapping sum.
				goal = tgt_pos + tgt_shift;
				here = motor_pos;
				if (goal > here) begin
					motor_pos = motor_pos + 32'd1;
					moved = 1'b1;
				end else if (goal < here) begin
					motor_pos = motor_pos - 32'd1;
					moved = 1'b1;
				end
				if (moved)
					coil_bits = coil_rows[motor_pos[2:0]];
			end
			shs_pkg::CMD_HOMING_POLL: begin
				if (home_phase > shs_pkg::PH_DONE) begin
					home_phase = shs_pkg::PH_PRE_TURN;
				end else if (home_phase == shs_pkg::PH_DONE) begin
					dn = 1'b1;
				end else begin
					// One poll may fall through several phases; go drops when a
					// phase decides to wait for a later poll.
					go = 1'b1;
					if (home_phase == shs_pkg::PH_PRE_TURN) begin
						if (at_edge)
							tgt_pos = cfg.main_turn_positive ? far_neg : far_pos;
						home_phase = shs_pkg::PH_MAIN_TURN;
					end
					if (go && home_phase == shs_pkg::PH_MAIN_TURN) begin
						if (at_edge) begin
							go = 1'b0;
						end else begin
							tgt_pos = cfg.main_turn_positive ? far_pos : far_neg;
							home_phase = shs_pkg::PH_ZEROING;
						end
					end
					if (go && home_phase == shs_pkg::PH_ZEROING) begin
						if (!at_edge) begin
							go = 1'b0;
						end else begin
							tgt_pos = '0;
							tgt_shift = '0;
							motor_pos = '0;
							creep_mark = w.now_ms;
							home_phase = shs_pkg::PH_CREEP;
						end
					end
					if (go && home_phase == shs_pkg::PH_CREEP) begin
						elapsed = w.now_ms - creep_mark;
						if (!at_edge) begin
							tgt_pos = '0;
							tgt_shift = '0;
							motor_pos = '0;
							home_phase = shs_pkg::PH_DONE;
						end else if (elapsed > {16'd0, cfg.slow_step_interval}) begin
							tgt_pos = tgt_pos + (cfg.main_turn_positive ? far_neg : far_pos);
							creep_mark = w.now_ms;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.coil_pattern = coil_bits;
		r.stepped = moved;
		r.actual_position = motor_pos;
		r.homing_done = dn;
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic [1:0] cmd, input logic [31:0] tp,
			input logic [31:0] to, input logic s, input logic [31:0] now, input bit known,
			input logic [3:0] coil, input logic st, input logic [31:0] pos, input logic dn);
		stim_row_t row;
		row.word.command = cmd;
		row.word.target_pos = tp;
		row.word.target_offset = to;
		row.word.sensor_level = s;
		row.word.now_ms = now;
		row.known = known;
		row.typed.coil_pattern = coil;
		row.typed.stepped = st;
		row.typed.actual_position = pos;
		row.typed.homing_done = dn;
		return row;
	endfunction

	// Offers one input word, with a random gap in front unless the run is in its
	// steady stretch. Valid stays up after acceptance; the next call either
	// replaces the word or drops valid for a gap.
	task automatic push_word(input shs_pkg::in_word_t w, input bit known,
			input shs_pkg::out_word_t typed);
		shs_pkg::out_word_t pred;
		while (!steady && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		pred = predict_out_word(w);
		pending_out_words.push_back(known ? typed : pred);
	endtask

	// Writes all four registers while the block is idle. Every owed word has to
	// come back first, then a few spare cycles cover the two-stage pipeline.
	task automatic load_settings(input shs_pkg::cfg_t c);
		in_valid <= 1'b0;
		while (pending_out_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= shs_pkg::REG_EDGE_LEVEL;
		wr_data <= {{(shs_pkg::FAR_W-1){1'b0}}, c.edge_level};
		@(posedge clk);
		wr_index <= shs_pkg::REG_MAIN_TURN_POSITIVE;
		wr_data <= {{(shs_pkg::FAR_W-1){1'b0}}, c.main_turn_positive};
		@(posedge clk);
		wr_index <= shs_pkg::REG_SLOW_STEP_INTERVAL;
		wr_data <= {{(shs_pkg::FAR_W-shs_pkg::IVL_W){1'b0}}, c.slow_step_interval};
		@(posedge clk);
		wr_index <= shs_pkg::REG_FAR_DISTANCE;
		wr_data <= c.far_distance;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg = c;
		settings_used++;
	endtask

	// Result side: the ready line idles at random, and every accepted result
	// word is checked against the oldest owed word, field by field.
	initial begin
		shs_pkg::out_word_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				words_checked++;
				if (out_word.stepped)
					moves_seen++;
				if (out_word.homing_done)
					done_seen++;
				if (pending_out_words.size() == 0) begin
					err_count++;
					$display("%0t: result word with nothing owed, expected none got %h",
						$time, out_word);
				end else begin
					want = pending_out_words.pop_front();
					if (want.coil_pattern !== out_word.coil_pattern) begin
						err_count++;
						$display("%0t: coil_pattern expected %h got %h", $time,
							want.coil_pattern, out_word.coil_pattern);
					end
					if (want.stepped !== out_word.stepped) begin
						err_count++;
						$display("%0t: stepped expected %b got %b", $time,
							want.stepped, out_word.stepped);
					end
					if (want.actual_position !== out_word.actual_position) begin
						err_count++;
						$display("%0t: actual_position expected %0d got %0d", $time,
							want.actual_position, out_word.actual_position);
					end
					if (want.homing_done !== out_word.homing_done) begin
						err_count++;
						$display("%0t: homing_done expected %b got %b", $time,
							want.homing_done, out_word.homing_done);
					end
				end
			end
			out_ready <= steady || ($urandom_range(0, 99) >= 30);
		end
	end

	// Stimulus: reset, a directed walk through the obvious cases, then five
	// random sections, each under its own register settings.
	initial begin
		stim_row_t          directed_rows [$];
		shs_pkg::cfg_t      plan [5];
		shs_pkg::cfg_t      first;
		shs_pkg::in_word_t  w;
		shs_pkg::out_word_t none;
		int          k;
		int          p;
		int          n;
		int          pick;
		int          item_no;
		logic [31:0] ms_now;
		logic [31:0] span;

		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= shs_pkg::REG_EDGE_LEVEL;
		wr_data <= '0;
		in_valid <= 1'b0;
		in_word <= '0;
		none = '0;
		err_count = 0;
		words_checked = 0;
		moves_seen = 0;
		done_seen = 0;
		settings_used = 0;
		steady = 1'b0;
		ms_now = 32'd200;

		cfg.edge_level = 1'b1;
		cfg.main_turn_positive = 1'b1;
		cfg.slow_step_interval = 16'd20;
		cfg.far_distance = 30'd100000;
		tgt_pos = '0;
		tgt_shift = '0;
		motor_pos = '0;
		home_phase = shs_pkg::PH_PRE_TURN;
		creep_mark = '0;
		coil_bits = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs with the main turn toward the negative side, so
		// that the pre-turn and main-turn targets of that direction are seen.
		first.edge_level = 1'b1;
		first.main_turn_positive = 1'b0;
		first.slow_step_interval = 16'd20;
		first.far_distance = 30'd100000;
		load_settings(first);

		// Right after reset, a no-op and a tick with nothing to do show zeros.
		directed_rows.push_back(mk_row(shs_pkg::CMD_NOP, 0, 0, 0, 0, 1, 4'h0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h0, 0, 0, 0));
		// Small moves up and down through the coil rows, then a tick at the goal.
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 5, 0, 0, 0, 1, 4'h0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h5, 1, 1, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 0, 32'hFFFF_FFFF, 0, 0, 1,
			4'h5, 0, 1, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h1, 1, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h9, 1,
			32'hFFFF_FFFF, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h9, 0,
			32'hFFFF_FFFF, 0));
		// Largest target plus one wraps to the most negative goal.
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 32'h7FFF_FFFF, 1, 0, 0, 1,
			4'h9, 0, 32'hFFFF_FFFF, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 1, 4'h8, 1,
			32'hFFFF_FFFE, 0));
		// Two most negative values sum to zero; other extreme pairs follow.
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 32'h8000_0000,
			32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 32'h7FFF_FFFF, 0, 0, 0,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_SET_TARGET, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Homing: pre-turn at the edge, main turn off the edge, then zeroing and
		// creeping, with the interval boundary and a time wrap.
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 1, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 1, 100,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 1, 120,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 1, 121,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_STEP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(shs_pkg::CMD_HOMING_POLL, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		// A no-op with every other field at all ones changes nothing.
		directed_rows.push_back(mk_row(shs_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			32'hFFFF_FFFF, 0, 0, 0, 0, 0));

		foreach (directed_rows[k])
			push_word(directed_rows[k].word, directed_rows[k].known, directed_rows[k].typed);

		// Settings for the random sections: both extremes first, then random ones.
		// The homing creep stays at the edge until the last section, where the
		// sensor is allowed to leave it and homing can finish.
		plan[0].edge_level = 1'b0;
		plan[0].main_turn_positive = 1'b1;
		plan[0].slow_step_interval = 16'd0;
		plan[0].far_distance = 30'd0;
		plan[1].edge_level = 1'b1;
		plan[1].main_turn_positive = 1'b1;
		plan[1].slow_step_interval = 16'hFFFF;
		plan[1].far_distance = 30'h3FFF_FFFF;
		plan[2].edge_level = 1'b0;
		plan[2].main_turn_positive = 1'b0;
		plan[2].slow_step_interval = 16'($urandom_range(0, 50));
		plan[2].far_distance = 30'($urandom_range(0, 1000));
		plan[3].edge_level = 1'b1;
		plan[3].main_turn_positive = 1'b1;
		plan[3].slow_step_interval = 16'($urandom);
		plan[3].far_distance = 30'($urandom);
		plan[4].edge_level = 1'($urandom_range(0, 1));
		plan[4].main_turn_positive = 1'($urandom_range(0, 1));
		plan[4].slow_step_interval = 16'($urandom_range(0, 30));
		plan[4].far_distance = 30'($urandom_range(0, 40));

		item_no = 0;
		for (p = 0; p < 5; p++) begin
			load_settings(plan[p]);
			for (n = 0; n < 130; n++) begin
				// One long stretch with no idling on either side.
				steady = (item_no >= 260 && item_no < 400);
				item_no++;
				pick = $urandom_range(0, 99);
				w.target_pos = $urandom;
				w.target_offset = $urandom;
				w.sensor_level = 1'($urandom_range(0, 1));
				w.now_ms = $urandom;
				if (pick < 25) begin
					// Mostly targets close to where the motor stands, so that it
					// reaches them and the no-move case shows up.
					w.command = shs_pkg::CMD_SET_TARGET;
					if ($urandom_range(0, 99) < 85) begin
						w.target_pos = motor_pos + $urandom_range(0, 60) - 32'd30;
						w.target_offset = $urandom_range(0, 20) - 32'd10;
					end
				end else if (pick < 70) begin
					w.command = shs_pkg::CMD_STEP_TICK;
				end else if (pick < 95) begin
					// Polls walk a millisecond clock forward in steps around the
					// creep interval, with an occasional jump anywhere.
					w.command = shs_pkg::CMD_HOMING_POLL;
					if (p == 4 && $urandom_range(0, 99) < 10)
						w.sensor_level = ~cfg.edge_level;
					else
						w.sensor_level = cfg.edge_level;
					span = {16'd0, cfg.slow_step_interval};
					ms_now = ms_now + $urandom_range(0, span + span / 2 + 2);
					if ($urandom_range(0, 99) < 5)
						ms_now = $urandom;
					w.now_ms = ms_now;
				end else begin
					w.command = shs_pkg::CMD_NOP;
				end
				push_word(w, 1'b0, none);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		k = 0;
		while (pending_out_words.size() != 0 && k < 20000) begin
			@(posedge clk);
			k++;
		end
		repeat (10) @(posedge clk);
		if (pending_out_words.size() != 0) begin
			err_count += pending_out_words.size();
			$display("%0t: %0d result words never arrived, expected 0 outstanding", $time,
				pending_out_words.size());
		end

		$display("Run covered %0d result words, %0d of them moves, under %0d register settings.",
			words_checked, moves_seen, settings_used);
		$display("Homing polls that reported a finished sequence: %0d.", done_seen);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard stop in case a handshake hangs.
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
design/shs_pkg.sv
design/shs_step.sv
design/shs_home.sv
design/stepper_half_step_homing_unit.sv
tb/sv/tb_top.sv
